/* hdl/mau_pkg.sv */
// Shared types and constants for the 4x4 matrix arithmetic unit.
// Used by the top level, the serial divider and the port checker.
// Depends on nothing.
package mau_pkg;

    // Matrix geometry and fixed-point format
    localparam int MATRIX_DIM    = 4;
    localparam int FRACTION_BITS = 16;
    localparam int CELLS         = MATRIX_DIM * MATRIX_DIM;
    localparam int POS_W         = $clog2(CELLS);
    localparam int DIM_W         = $clog2(MATRIX_DIM);
    localparam int XFORM_DIM     = (MATRIX_DIM < 3) ? MATRIX_DIM : 3;

    // Accumulator: a 64-bit product after the fraction shift, plus growth over one row
    localparam int ACC_W = 64 - FRACTION_BITS + $clog2(MATRIX_DIM) + 1;

    // Divider: dividend is |A| with the fraction bits appended
    localparam int DVD_W     = 32 + FRACTION_BITS;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    // Operation codes
    localparam logic [3:0] OP_WRITE_A   = 4'd0;
    localparam logic [3:0] OP_WRITE_B   = 4'd1;
    localparam logic [3:0] OP_ADD       = 4'd2;
    localparam logic [3:0] OP_SUB       = 4'd3;
    localparam logic [3:0] OP_MUL       = 4'd4;
    localparam logic [3:0] OP_SCALE     = 4'd5;
    localparam logic [3:0] OP_DIVIDE    = 4'd6;
    localparam logic [3:0] OP_TRANSPOSE = 4'd7;
    localparam logic [3:0] OP_TRANSFORM = 4'd8;

    // Saturation limits
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Input word
    typedef struct packed {
        logic [3:0]         operation;
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        logic signed [31:0] scalar;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [3:0]         result_index;
        logic signed [31:0] result_value;
        logic               error_flag;
        logic               last;
    } t_out_word;

    // Divider status towards the sequencer
    typedef struct packed {
        logic               done;
        logic               err;
        logic signed [31:0] quot;
    } t_div_rsp;

endpackage

/* hdl/mau_div.sv */
// Serial restoring divider: (A * 2^FRACTION_BITS) / divisor, truncated toward zero,
// saturated to 32 bits, one quotient bit per cycle. Depends on mau_pkg.
module mau_div import mau_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_dividend,
    input  logic signed [31:0] i_divisor,
    output t_div_rsp           o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_dvd;
    logic [31:0]          r_rem;
    logic [31:0]          r_dsr;
    logic                 r_neg;
    logic                 r_zero;
    logic                 r_a_pos;
    logic                 r_a_neg;

    logic [31:0] a_mag;
    logic [31:0] s_mag;
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        ge;
    logic        pos_ovf;
    logic        neg_ovf;

    // Operand magnitudes; the most negative value maps to 2^31
    assign a_mag = i_dividend[31] ? (~i_dividend + 32'd1) : i_dividend;
    assign s_mag = i_divisor[31]  ? (~i_divisor + 32'd1)  : i_divisor;

    // One restoring step: shift in the next dividend bit, try the subtract
    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign diff   = rem_sh - {1'b0, r_dsr};
    assign ge     = ~diff[32];

    // Sequencing of the shift-subtract loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_dvd   <= {a_mag, {FRACTION_BITS{1'b0}}};
                r_rem   <= '0;
                r_dsr   <= s_mag;
                r_neg   <= i_dividend[31] ^ i_divisor[31];
                r_zero  <= (i_divisor == '0);
                r_a_pos <= !i_dividend[31] && (i_dividend != '0);
                r_a_neg <= i_dividend[31];
                r_cnt   <= '0;
                // zero divisor needs no iterations
                r_done  <= (i_divisor == '0);
                if (i_divisor != '0) begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_dvd  <= {r_dvd[DVD_W-2:0], ge};
                r_rem  <= ge ? diff[31:0] : rem_sh[31:0];
                r_cnt  <= r_cnt + 1'b1;
                r_done <= (r_cnt == DIV_CNT_W'(DVD_W - 1));
                if (r_cnt == DIV_CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // Sign and saturation of the finished quotient (r_dvd now holds it)
    assign pos_ovf = |r_dvd[DVD_W-1:31];
    assign neg_ovf = (|r_dvd[DVD_W-1:32]) || (r_dvd[31] && (|r_dvd[30:0]));

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.err  = 1'b0;
        o_rsp.quot = '0;
        if (r_zero) begin
            o_rsp.err = 1'b1;
            if (r_a_pos) begin
                o_rsp.quot = Q_MAX;
            end else if (r_a_neg) begin
                o_rsp.quot = Q_MIN;
            end
        end else if (r_neg) begin
            if (neg_ovf) begin
                o_rsp.err  = 1'b1;
                o_rsp.quot = Q_MIN;
            end else begin
                o_rsp.quot = ~r_dvd[31:0] + 32'd1;
            end
        end else begin
            if (pos_ovf) begin
                o_rsp.err  = 1'b1;
                o_rsp.quot = Q_MAX;
            end else begin
                o_rsp.quot = r_dvd[31:0];
            end
        end
    end

endmodule

/* hdl/matrix4_arithmetic_unit_top.sv */
// Top level of the 4x4 matrix arithmetic unit: matrix store, sequencer, shared
// multiplier and accumulator, output register. Depends on mau_pkg and mau_div.
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+-----------------------------------
//  input    | in        | i_valid / o_stall  | i_word : t_in_word (op, index, ...)
//  result   | out       | o_valid / i_stall  | o_word : t_out_word (index, value)
//
// Per element, add, sub, transpose pass S_LOAD, S_EXEC, S_EMIT; scale adds S_ACC; mul
// and transform loop S_LOAD, S_EXEC, S_ACC over MATRIX_DIM or XFORM_DIM steps, then
// S_EMIT; divide waits in S_DIV for the one-bit-per-cycle divider, which skips its
// loop for a zero divisor. One shared 32x32 multiplier. A held result word delays
// the next element. o_stall stays high from the start of an operation until its last
// word is loaded. Reset clears both matrices and all control state.
module matrix4_arithmetic_unit_top import mau_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_EXEC,
        S_ACC,
        S_DIV,
        S_EMIT
    } t_state;

    localparam logic [POS_W-1:0] DIM_P      = POS_W'(MATRIX_DIM);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(CELLS - 1);
    localparam logic [DIM_W-1:0] DIM_LAST   = DIM_W'(MATRIX_DIM - 1);
    localparam logic [DIM_W-1:0] XFORM_LAST = DIM_W'(XFORM_DIM - 1);

    t_state r_state;

    // Matrix store
    logic signed [31:0] r_mat_a [CELLS];
    logic signed [31:0] r_mat_b [CELLS];

    // Operation context
    logic [3:0]         r_op;
    logic signed [31:0] r_scalar;
    logic [POS_W-1:0]   r_pos;
    logic [DIM_W-1:0]   r_row;
    logic [DIM_W-1:0]   r_col;
    logic [DIM_W-1:0]   r_k;

    // Datapath
    logic signed [31:0]      r_opa;
    logic signed [31:0]      r_opb;
    logic signed [63:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_derr;

    // Output register
    logic      r_o_valid;
    t_out_word r_o_word;

    logic [POS_W-1:0]   a_addr;
    logic [POS_W-1:0]   b_addr;
    logic [POS_W-1:0]   row_p;
    logic [POS_W-1:0]   col_p;
    logic [POS_W-1:0]   k_p;
    logic signed [31:0] mul_b;
    logic [DIM_W-1:0]   k_last;
    logic               elem_last;
    logic               out_free;
    logic               emit_go;
    logic [ACC_W-32:0]  acc_hi;
    logic               acc_ovf;
    logic signed [31:0] sat_val;
    logic               wr_ok;
    t_div_rsp           div_rsp;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;
    assign o_word  = r_o_word;

    // Operand addresses for the current element and step
    assign row_p = POS_W'(r_row);
    assign col_p = POS_W'(r_col);
    assign k_p   = POS_W'(r_k);

    always_comb begin
        a_addr = r_pos;
        b_addr = r_pos;
        unique case (r_op)
            OP_MUL: begin
                a_addr = row_p * DIM_P + k_p;
                b_addr = k_p * DIM_P + col_p;
            end
            OP_TRANSFORM: begin
                a_addr = row_p * DIM_P + k_p;
                b_addr = k_p;
            end
            OP_TRANSPOSE: begin
                a_addr = col_p * DIM_P + row_p;
            end
            default: begin
                a_addr = r_pos;
                b_addr = r_pos;
            end
        endcase
    end

    // Loop bounds
    assign mul_b     = (r_op == OP_SCALE) ? r_scalar : r_opb;
    assign k_last    = (r_op == OP_TRANSFORM) ? XFORM_LAST : DIM_LAST;
    assign elem_last = (r_op == OP_TRANSFORM) ? (r_row == XFORM_LAST) : (r_pos == POS_LAST);
    assign out_free  = !r_o_valid || !i_stall;
    assign emit_go   = (r_state == S_EMIT) && out_free;
    assign wr_ok     = 32'(i_word.element_index) < 32'(CELLS);

    // Saturate the accumulator to 32 bits
    assign acc_hi  = r_acc[ACC_W-1:31];
    assign acc_ovf = !((&acc_hi) || !(|acc_hi));
    assign sat_val = acc_ovf ? (r_acc[ACC_W-1] ? Q_MIN : Q_MAX) : r_acc[31:0];

    // Shared serial divider
    mau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_EXEC) && (r_op == OP_DIVIDE)),
        .i_dividend (r_opa),
        .i_divisor  (r_scalar),
        .o_rsp      (div_rsp)
    );

    // Sequencer, store and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_pos     <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_k       <= '0;
            r_acc     <= '0;
            r_derr    <= 1'b0;
            r_op      <= OP_WRITE_A;
            for (int i = 0; i < CELLS; i++) begin
                r_mat_a[i] <= '0;
                r_mat_b[i] <= '0;
            end
        end else begin
            // result word taken and no new one loaded
            if (r_o_valid && !i_stall && !emit_go) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op     <= i_word.operation;
                        r_scalar <= i_word.scalar;
                        r_pos    <= '0;
                        r_row    <= '0;
                        r_col    <= '0;
                        r_k      <= '0;
                        r_acc    <= '0;
                        r_derr   <= 1'b0;
                        case (i_word.operation) inside
                            OP_WRITE_A: begin
                                if (wr_ok) begin
                                    r_mat_a[POS_W'(i_word.element_index)] <=
                                        i_word.element_value;
                                end
                            end
                            OP_WRITE_B: begin
                                if (wr_ok) begin
                                    r_mat_b[POS_W'(i_word.element_index)] <=
                                        i_word.element_value;
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_SCALE, OP_DIVIDE,
                            OP_TRANSPOSE, OP_TRANSFORM: begin
                                r_state <= S_LOAD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_LOAD: begin
                    r_opa   <= r_mat_a[a_addr];
                    r_opb   <= r_mat_b[b_addr];
                    r_state <= S_EXEC;
                end

                S_EXEC: begin
                    case (r_op)
                        OP_ADD: begin
                            r_acc   <= ACC_W'(r_opa) + ACC_W'(r_opb);
                            r_state <= S_EMIT;
                        end
                        OP_SUB: begin
                            r_acc   <= ACC_W'(r_opa) - ACC_W'(r_opb);
                            r_state <= S_EMIT;
                        end
                        OP_TRANSPOSE: begin
                            r_acc   <= ACC_W'(r_opa);
                            r_state <= S_EMIT;
                        end
                        OP_DIVIDE: begin
                            r_state <= S_DIV;
                        end
                        default: begin
                            r_prod  <= r_opa * mul_b;
                            r_state <= S_ACC;
                        end
                    endcase
                end

                // products are truncated before they are summed
                S_ACC: begin
                    r_acc <= r_acc + ACC_W'(r_prod >>> FRACTION_BITS);
                    if ((r_op == OP_SCALE) || (r_k == k_last)) begin
                        r_k     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_LOAD;
                    end
                end

                S_DIV: begin
                    if (div_rsp.done) begin
                        r_acc   <= ACC_W'(div_rsp.quot);
                        r_derr  <= div_rsp.err;
                        r_state <= S_EMIT;
                    end
                end

                S_EMIT: begin
                    if (out_free) begin
                        r_o_valid                <= 1'b1;
                        r_o_word.result_index    <= 4'(r_pos);
                        r_o_word.result_value    <= sat_val;
                        r_o_word.error_flag      <= acc_ovf || r_derr;
                        r_o_word.last            <= elem_last;
                        r_acc                    <= '0;
                        r_derr                   <= 1'b0;
                        r_pos                    <= r_pos + 1'b1;
                        if ((r_op == OP_TRANSFORM) || (r_col == DIM_LAST)) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        r_state <= elem_last ? S_IDLE : S_LOAD;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/mau_checker.sv */
// Port-level checks for the matrix arithmetic unit, bound to the top level.
// Depends on mau_pkg and matrix4_arithmetic_unit_top.
module mau_checker import mau_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_word  i_word,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_word o_word
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("result word changed while stalled");

    // An accepted operation blocks the input until its run is done
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall &&
        (i_word.operation == OP_ADD || i_word.operation == OP_SUB ||
         i_word.operation == OP_MUL || i_word.operation == OP_SCALE ||
         i_word.operation == OP_DIVIDE || i_word.operation == OP_TRANSPOSE ||
         i_word.operation == OP_TRANSFORM)
        |=> o_stall)
        else $error("input not blocked after an operation was accepted");

    // A matrix write produces no result word
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && i_valid && !o_stall &&
        (i_word.operation == OP_WRITE_A || i_word.operation == OP_WRITE_B)
        |=> !o_valid && !o_stall)
        else $error("matrix write produced a result word");

    // The input reopens exactly when the final word of a run is presented
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_stall) |-> o_valid && o_word.last)
        else $error("run ended without its last word");

endmodule

bind matrix4_arithmetic_unit_top mau_checker u_mau_checker (.*);
